[rtl/mpaq_pkg.sv]
// Shared definitions for the min priority array queue: depth, widths,
// command and status codes, controller states and the cell interface structs.
// No dependencies.
package mpaq_pkg;

    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 4;

    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // Broadcast control from the controller to every cell.
    typedef struct packed {
        logic                     wr_en;
        logic [IDX_W-1:0]         wr_idx;
        logic signed [DATA_W-1:0] wr_data;
        logic                     shift_en;
        logic [IDX_W-1:0]         best_idx;
        logic [CNT_W-1:0]         count;
    } cell_ctrl_t;

    // Minimum-search wave handed from one cell to the next.
    typedef struct packed {
        logic                     pulse;
        logic                     has;
        logic signed [DATA_W-1:0] val;
        logic [IDX_W-1:0]         idx;
    } wave_t;

endpackage

[rtl/mpaq_cell.sv]
// One storage cell of the min priority array queue: holds one entry, takes
// part in the minimum-search wave and in the shift-down after a removal.
// Depends on mpaq_pkg.
module mpaq_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mpaq_pkg::IDX_W-1:0]        slot,
    input  mpaq_pkg::cell_ctrl_t              ctrl,
    input  logic signed [mpaq_pkg::DATA_W-1:0] right_entry,
    input  mpaq_pkg::wave_t                   wave_in,
    output mpaq_pkg::wave_t                   wave_out,
    output logic signed [mpaq_pkg::DATA_W-1:0] entry
);
    import mpaq_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    wave_t                    wave_reg;
    wave_t                    wave_next;
    logic                     occupied;
    logic                     take_own;

    assign occupied = CNT_W'(slot) < ctrl.count;
    assign take_own = occupied && (!wave_in.has || (entry_reg < wave_in.val));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.wr_en && (slot == ctrl.wr_idx))
        begin
            entry_next = ctrl.wr_data;
        end
        else if (ctrl.shift_en && (slot >= ctrl.best_idx))
        begin
            entry_next = right_entry;
        end
    end

    always_comb
    begin
        wave_next       = wave_reg;
        wave_next.pulse = wave_in.pulse;
        if (wave_in.pulse)
        begin
            if (take_own)
            begin
                wave_next.has = 1'b1;
                wave_next.val = entry_reg;
                wave_next.idx = slot;
            end
            else
            begin
                wave_next.has = wave_in.has;
                wave_next.val = wave_in.val;
                wave_next.idx = wave_in.idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;
    assign entry    = entry_reg;

endmodule

[rtl/min_priority_array_queue.sv]
// Top level of the min priority array queue: controller, output register
// and the row of storage cells. Depends on mpaq_pkg and mpaq_cell.
//
// Usage. Input words carry a command and a data value on in_valid/in_ready;
// result words carry status, value and occupancy on out_valid/out_ready.
// Every accepted input word produces exactly one result word, in order.
// Enqueue appends at the tail, dequeue removes the smallest signed entry
// (earliest slot on ties), peek returns slot zero, the oldest entry.
//
// Sequence. Enqueue, peek, unused commands and a dequeue of an empty queue
// work at acceptance and go straight to the done state. Any other dequeue
// sends a search wave through the row of DEPTH cells, one cell per cycle,
// then shifts later entries down in the shift state before it reaches the
// done state. From there the result moves into the output register and the
// controller goes back to idle; only there is the next word taken, so a new
// word is never accepted while the previous one is still being worked on.
//
// Reset clears the entry count, the controller and the output valid; the
// entries themselves hold no reset value and are never read before written.
// When the receiver stalls the result word is held in the output register,
// and one further input word can be accepted and completed; its result then
// waits in the controller until the output register frees up.
module min_priority_array_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         command,
    input  logic signed [mpaq_pkg::DATA_W-1:0] data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [mpaq_pkg::DATA_W-1:0] value,
    output logic [mpaq_pkg::OCC_W-1:0]         occupancy
);
    import mpaq_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    status_t                  res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_value_reg, res_value_next;

    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic [OCC_W-1:0]         out_occ_reg, out_occ_next;

    cell_ctrl_t               ctrl;
    logic                     accept;
    logic                     scan_start;
    logic                     out_load;

    wave_t                    wave_chain [DEPTH+1];
    logic signed [DATA_W-1:0] entry_row  [DEPTH];

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // The search wave enters slot zero empty-handed; each cell keeps the
    // smaller of what it receives and its own entry, strict less keeps ties
    // at the earlier slot.
    assign wave_chain[0].pulse = scan_start;
    assign wave_chain[0].has   = 1'b0;
    assign wave_chain[0].val   = '0;
    assign wave_chain[0].idx   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] right_val;
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_val = entry_row[gi];
            end
            else
            begin : g_mid
                assign right_val = entry_row[gi+1];
            end

            mpaq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .slot        (IDX_W'(gi)),
                .ctrl        (ctrl),
                .right_entry (right_val),
                .wave_in     (wave_chain[gi]),
                .wave_out    (wave_chain[gi+1]),
                .entry       (entry_row[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        best_idx_next   = best_idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        scan_start      = 1'b0;

        ctrl.wr_en    = 1'b0;
        ctrl.wr_idx   = count_reg[IDX_W-1:0];
        ctrl.wr_data  = data;
        ctrl.shift_en = 1'b0;
        ctrl.best_idx = best_idx_reg;
        ctrl.count    = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    state_next      = S_DONE;
                    unique case (command)
                        CMD_ENQ:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.wr_en = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                scan_start = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                res_value_next = entry_row[0];
                            end
                        end
                        default:
                        begin
                            // Unused command: no state change, plain ok result.
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (wave_chain[DEPTH].pulse)
                begin
                    best_idx_next  = wave_chain[DEPTH].idx;
                    res_value_next = wave_chain[DEPTH].val;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // Every slot from the removed one upward takes its right
                // neighbor in a single step.
                ctrl.shift_en = 1'b1;
                count_next    = count_reg - 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_occ_next    = out_occ_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_value_next  = res_value_reg;
            out_occ_next    = OCC_W'(count_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_occ_reg    <= out_occ_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign value     = out_value_reg;
    assign occupancy = out_occ_reg;

endmodule

[verif/mpaq_result_book_pkg.sv]
// Scoreboard for the min priority array queue testbench: a shadow copy of the
// stored entries, the results it owes, and the field-by-field result check.
// Depends on mpaq_pkg for the depth, widths, command and status codes.
package mpaq_result_book_pkg;

    import mpaq_pkg::*;

    // The command field is two bits wide; this code is the one the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value;
        logic [OCC_W-1:0]         occupancy;
    } queue_reply_t;

    class queue_result_book;

        logic signed [DATA_W-1:0] shadow_entries[$];
        queue_reply_t             owed_replies[$];
        int unsigned              mismatches;

        function new();
            shadow_entries.delete();
            owed_replies.delete();
            mismatches = 0;
        endfunction

        // Applies one command to the shadow entries and returns the reply it earns.
        function queue_reply_t apply_command(logic [1:0] cmd, logic signed [DATA_W-1:0] din);
            queue_reply_t reply;
            int           best;
            reply.status = ST_OK;
            reply.value  = '0;
            case (cmd)
                CMD_ENQ:
                begin
                    if (shadow_entries.size() >= DEPTH)
                        reply.status = ST_FULL;
                    else
                        shadow_entries.push_back(din);
                end
                CMD_DEQ:
                begin
                    if (shadow_entries.size() == 0)
                        reply.status = ST_EMPTY;
                    else
                    begin
                        // Strict less-than keeps the earliest slot on ties.
                        best = 0;
                        for (int i = 1; i < shadow_entries.size(); i++)
                            if (shadow_entries[i] < shadow_entries[best])
                                best = i;
                        reply.value = shadow_entries[best];
                        shadow_entries.delete(best);
                    end
                end
                CMD_PEEK:
                begin
                    if (shadow_entries.size() == 0)
                        reply.status = ST_EMPTY;
                    else
                        reply.value = shadow_entries[0];
                end
                default:
                begin
                end
            endcase
            reply.occupancy = OCC_W'(shadow_entries.size());
            return reply;
        endfunction

        function void note_command(logic [1:0] cmd, logic signed [DATA_W-1:0] din);
            owed_replies.push_back(apply_command(cmd, din));
        endfunction

        function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] val,
                                   logic [OCC_W-1:0] occ);
            queue_reply_t want;
            if (owed_replies.size() == 0)
            begin
                $error("result word with no command outstanding: status %0d value %0d",
                       st, val);
                mismatches++;
                return;
            end
            want = owed_replies.pop_front();
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                mismatches++;
            end
            if (val !== want.value)
            begin
                $error("value: expected %0d, got %0d", want.value, val);
                mismatches++;
            end
            if (occ !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, occ);
                mismatches++;
            end
        endfunction

        function int pending();
            return owed_replies.size();
        endfunction

    endclass

endpackage

[verif/tb_top.sv]
// Top-level testbench for min_priority_array_queue: clock, reset, command
// driver, result receiver and an activity watchdog.
// Depends on mpaq_pkg, mpaq_result_book_pkg and the block itself.
module tb_top;

    import mpaq_pkg::*;
    import mpaq_result_book_pkg::*;

    // Number of random command words after the directed opening.
    localparam int RANDOM_WORDS = 1300;
    // Length of the receiver's long hold-off, in which it refuses results.
    localparam int HOLD_CYCLES  = 200;
    // Cycles with no accepted word, on either side, before the run is abandoned.
    // The longest legal quiet spell is the hold-off above plus one dequeue.
    localparam int STALL_LIMIT  = 2000;
    // Drain time after the last expected result, scaled by the queue depth.
    localparam int DRAIN_CYCLES = 4 * (DEPTH + 3);

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               command;
    logic signed [DATA_W-1:0] data;
    logic                     out_valid;
    logic                     out_ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value;
    logic [OCC_W-1:0]         occupancy;

    // While calm is set neither side inserts idle cycles.
    bit calm         = 1'b0;
    // Set by the driver to ask the receiver for one long hold-off.
    bit hold_request = 1'b0;

    queue_result_book book = new();

    min_priority_array_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .data      (data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .value     (value),
        .occupancy (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one input word and returns at the edge where it is accepted.
    // Idle cycles are only inserted before valid goes high, so once a word is
    // offered it stays put until the block takes it. Everything here runs just
    // after a rising edge, so in_ready is read as it was at that edge.
    task automatic send_word(input logic [1:0] cmd, input logic signed [DATA_W-1:0] din);
        while (!calm && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        data     <= din;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_command(cmd, din);
    endtask

    // Data mix: a narrow band around zero so that ties and duplicate minima
    // are common, the signed extremes now and then, and full 32-bit noise.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return $signed(DATA_W'($urandom_range(0, 8))) - 32'sd4;
        else if (roll < 35)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom());
    endfunction

    // Result side. Results are sampled just after each rising edge, so the
    // handshake and payload are the values the block presented at that edge.
    // Ready drops at random with odds of 9 in 100, never during the calm
    // stretch, and once for a long hold-off that lets the block back up and
    // stall its input.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                book.check_result(status, value, occupancy);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_ready   <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 9);
        end
    end

    // Watchdog: any accepted word on either side restarts the count. A run
    // that goes quiet for too long is reported as a failure.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence: reset, directed opening, random phase, drain and verdict.
    initial
    begin
        int unsigned n;
        int unsigned roll;
        bit          filling;
        logic [1:0]  cmd;

        filling   = 1'b1;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        command  <= CMD_ENQ;
        data     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. An empty queue must refuse dequeue and peek, and
        // the unused command must leave everything alone.
        send_word(CMD_PEEK, $signed($urandom()));
        send_word(CMD_DEQ, $signed($urandom()));
        send_word(CMD_UNUSED, $signed($urandom()));

        // Fill all eight slots. The oldest entry is the largest value, and the
        // most negative value sits in slot one and again in the last slot, so
        // the dequeue must pick the earlier copy.
        send_word(CMD_ENQ, 32'sh7FFF_FFFF);
        send_word(CMD_ENQ, 32'sh8000_0000);
        send_word(CMD_ENQ, 32'sd0);
        send_word(CMD_ENQ, -32'sd1);
        send_word(CMD_ENQ, 32'sd5);
        send_word(CMD_ENQ, -32'sd1);
        send_word(CMD_ENQ, 32'sd1);
        send_word(CMD_ENQ, 32'sh8000_0000);

        // A push to a full queue is refused; peek shows the oldest entry, not
        // the minimum; the unused command reports the full count.
        send_word(CMD_ENQ, 32'sh1234_5678);
        send_word(CMD_PEEK, $signed($urandom()));
        send_word(CMD_UNUSED, $signed($urandom()));

        // Drain completely, with a peek once the two minima are gone, then
        // check the empty reports again.
        send_word(CMD_DEQ, $signed($urandom()));
        send_word(CMD_DEQ, $signed($urandom()));
        send_word(CMD_PEEK, $signed($urandom()));
        repeat (6) send_word(CMD_DEQ, $signed($urandom()));
        send_word(CMD_DEQ, $signed($urandom()));
        send_word(CMD_PEEK, $signed($urandom()));

        // Random phase. The command mix tilts toward filling or draining in
        // runs of forty words, so the queue keeps swinging between empty and
        // full and both boundary reports show up often.
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
                filling = 1'($urandom_range(0, 1));
            if (n == 300)
                hold_request = 1'b1;
            calm = (n >= 600 && n < 850);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                cmd = CMD_UNUSED;
            else if (roll < 12)
                cmd = CMD_PEEK;
            else if (roll < (filling ? 72 : 40))
                cmd = CMD_ENQ;
            else
                cmd = CMD_DEQ;
            send_word(cmd, pick_value());
        end
        in_valid <= 1'b0;
        calm      = 1'b0;

        // Wait for every owed result, then leave time for anything stray.
        while (book.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.mismatches == 0 && book.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
